// ===== src/tpao_pkg.sv =====
package tpao_pkg;

   localparam int CSR_COUNT       = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_FIRST_LOW_EDGE   = 3'd0,
      REG_FIRST_HIGH_EDGE  = 3'd1,
      REG_FIRST_SENSE_Z    = 3'd2,
      REG_FIRST_OTHER_Z    = 3'd3,
      REG_SECOND_LOW_EDGE  = 3'd4,
      REG_SECOND_HIGH_EDGE = 3'd5,
      REG_SECOND_SENSE_Z   = 3'd6,
      REG_SECOND_OTHER_Z   = 3'd7
   } csr_reg_type;

   // four projected intervals: each unit seen at its sensing and its opposite face
   localparam int FACE_COUNT = 4;

   // slice width of the slope magnitude fed to each face multiplier
   localparam int MUL_CHUNK = 32;

   // slope magnitude clamps at 2^63 - 1 once the quotient reaches 2^64 (one extra bit held)
   localparam int SLOPE_SAT_BIT = 63;
   localparam int SLOPE_OVF_BIT = 64;

   // face shift magnitude clamps at 2^61
   localparam int SHIFT_SAT_BIT = 61;

   typedef struct packed {
      logic vld;
      logic deg;
   } tag_type;

endpackage

// ===== src/two_plane_aperture_overlap.sv =====
// Aperture overlap of two detector units along one axis.
//
// Configuration: eight registers on the csr_ port (edges and face z of both
// units), written with csr_we, csr_index and csr_wdata, one per clock. The user
// must write them only while no item is in flight; the block does not enforce it.
// Input: an item is a hit offset on req_offset, taken at an edge where start
// is high and busy is low. busy is low in normal operation, so one item may
// be taken on every clock.
// Output: each item gives one result on rsp_overlap_length and
// rsp_degenerate, marked by rsp_strobe for a single cycle. Results come out
// in the order the items came in.
// Pipeline: entry and load stages, then the restoring slope divider, one quotient
// bit per stage over COORD_WIDTH + SLOPE_FRAC_BITS + 3 stages, then eight stages
// of slope rounding, multiply, sum, round and clip, edge shift, intersect, length.
// Throughput: one item per clock, sustained.
// Reset (synchronous): clears every in-flight item and the configuration
// registers to zero; busy is high during reset and falls at the first edge after it.
// The receiver cannot hold results off; none is ever needed to wait.
module two_plane_aperture_overlap #(
   parameter int COORD_WIDTH     = 24,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_offset,
   input  logic                                  csr_we,
   input  logic [tpao_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata,
   output logic                                  rsp_strobe,
   output logic [COORD_WIDTH-1:0]                rsp_overlap_length,
   output logic                                  rsp_degenerate
);
   import tpao_pkg::*;

   localparam int NUMW  = COORD_WIDTH + 3;               // signed numerator
   localparam int NW    = COORD_WIDTH + 2;               // numerator magnitude
   localparam int DDW   = COORD_WIDTH + 1;               // divisor and remainder
   localparam int DW    = NW + SLOPE_FRAC_BITS + 1;      // dividend and quotient
   localparam int SMW   = COORD_WIDTH + SLOPE_FRAC_BITS + 1;
   localparam int NCH   = (SMW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int PADW  = NCH * MUL_CHUNK;
   localparam int PPW   = MUL_CHUNK + COORD_WIDTH;
   localparam int PW    = PADW + COORD_WIDTH;
   localparam int SHW   = PW + 1 - SLOPE_FRAC_BITS;
   localparam int SMAGW = (SHW < SHIFT_SAT_BIT + 1) ? SHW : SHIFT_SAT_BIT + 1;
   localparam int CMPW  = (SHW > SHIFT_SAT_BIT + 1) ? SHW : SHIFT_SAT_BIT + 1;
   localparam int EW    = SMAGW + 2;
   localparam int DIFW  = EW + 1;

   localparam logic [SMW-1:0]  SLOPE_SAT     =
      SMW'((64'(1) << SLOPE_SAT_BIT) - 64'(1));
   localparam logic [PW:0]     ROUND_HALF    = (PW + 1)'(1) << (SLOPE_FRAC_BITS - 1);
   localparam logic [CMPW-1:0] SHIFT_SAT_VAL = CMPW'(1) << SHIFT_SAT_BIT;

   // configuration
   logic signed [COORD_WIDTH-1:0] cfg_ff [CSR_COUNT];
   logic signed [COORD_WIDTH-1:0] face_z  [FACE_COUNT];
   logic signed [COORD_WIDTH-1:0] face_lo [FACE_COUNT];
   logic signed [COORD_WIDTH-1:0] face_hi [FACE_COUNT];
   logic [COORD_WIDTH-1:0]        z_mag   [FACE_COUNT];
   logic signed [COORD_WIDTH:0]   z_diff;
   logic [COORD_WIDTH-1:0]        z_gap;
   logic [DDW-1:0]                divisor;
   logic                          z_equal;

   logic busy_ff;

   // entry stage
   logic signed [NUMW-1:0] num_in;
   logic signed [NUMW-1:0] num_ff;
   tag_type                entry_tag_in;
   tag_type                entry_tag_ff;
   logic [NW-1:0]          num_mag;
   logic                   num_neg;

   // divider stages: entry 0 holds the loaded dividend, entry DW the quotient
   logic [DDW-1:0] div_rem_ff [DW+1];
   logic [DW-1:0]  div_x_ff   [DW+1];
   logic           div_neg_ff [DW+1];
   tag_type        div_tag_ff [DW+1];
   logic [DDW:0]   div_trial  [DW];
   logic           div_ge     [DW];
   logic [DDW-1:0] div_rem_in [DW];
   logic [DW-1:0]  div_x_in   [DW];

   // slope
   logic [DW:0]    q_inc;
   logic           q_ovf;
   logic [SMW-1:0] m_in;
   logic [SMW-1:0] m_ff;
   logic           m_neg_ff;
   tag_type        m_tag_ff;
   logic [PADW-1:0] m_pad;

   // face products
   logic [PPW-1:0] mul_pp_in  [FACE_COUNT][NCH];
   logic [PPW-1:0] mul_pp_ff  [FACE_COUNT][NCH];
   logic           mul_neg_in [FACE_COUNT];
   logic           mul_neg_ff [FACE_COUNT];
   tag_type        mul_tag_ff;

   logic [PW-1:0]  sum_prod_in [FACE_COUNT];
   logic [PW-1:0]  sum_prod_ff [FACE_COUNT];
   logic           sum_neg_ff  [FACE_COUNT];
   tag_type        sum_tag_ff;

   logic [PW:0]      rnd_full   [FACE_COUNT];
   logic [SHW-1:0]   rnd_shift  [FACE_COUNT];
   logic             rnd_sat    [FACE_COUNT];
   logic [SMAGW-1:0] rnd_mag_in [FACE_COUNT];
   logic [SMAGW-1:0] rnd_mag_ff [FACE_COUNT];
   logic             rnd_neg_ff [FACE_COUNT];
   tag_type          rnd_tag_ff;

   // shifted intervals and their intersection
   logic signed [EW-1:0] edge_min_in [FACE_COUNT];
   logic signed [EW-1:0] edge_max_in [FACE_COUNT];
   logic signed [EW-1:0] edge_min_ff [FACE_COUNT];
   logic signed [EW-1:0] edge_max_ff [FACE_COUNT];
   tag_type              edge_tag_ff;

   logic signed [EW-1:0] pair_lo_in [2];
   logic signed [EW-1:0] pair_hi_in [2];
   logic signed [EW-1:0] pair_lo_ff [2];
   logic signed [EW-1:0] pair_hi_ff [2];
   tag_type              pair_tag_ff;

   logic signed [EW-1:0] span_lo_in;
   logic signed [EW-1:0] span_hi_in;
   logic signed [EW-1:0] span_lo_ff;
   logic signed [EW-1:0] span_hi_ff;
   tag_type              span_tag_ff;

   logic signed [DIFW-1:0] span_diff;
   logic [COORD_WIDTH-1:0] out_len_in;
   logic [COORD_WIDTH-1:0] out_len_ff;
   tag_type                out_tag_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      face_z[0]  = cfg_ff[REG_FIRST_SENSE_Z];
      face_z[1]  = cfg_ff[REG_FIRST_OTHER_Z];
      face_z[2]  = cfg_ff[REG_SECOND_SENSE_Z];
      face_z[3]  = cfg_ff[REG_SECOND_OTHER_Z];
      face_lo[0] = cfg_ff[REG_FIRST_LOW_EDGE];
      face_lo[1] = cfg_ff[REG_FIRST_LOW_EDGE];
      face_lo[2] = cfg_ff[REG_SECOND_LOW_EDGE];
      face_lo[3] = cfg_ff[REG_SECOND_LOW_EDGE];
      face_hi[0] = cfg_ff[REG_FIRST_HIGH_EDGE];
      face_hi[1] = cfg_ff[REG_FIRST_HIGH_EDGE];
      face_hi[2] = cfg_ff[REG_SECOND_HIGH_EDGE];
      face_hi[3] = cfg_ff[REG_SECOND_HIGH_EDGE];
      for (int f = 0; f < FACE_COUNT; f++) begin
         z_mag[f] = face_z[f][COORD_WIDTH-1] ? COORD_WIDTH'(-face_z[f])
                                             : COORD_WIDTH'(face_z[f]);
      end
      z_diff  = (COORD_WIDTH + 1)'(cfg_ff[REG_FIRST_SENSE_Z])
              - (COORD_WIDTH + 1)'(cfg_ff[REG_SECOND_SENSE_Z]);
      z_gap   = z_diff[COORD_WIDTH] ? COORD_WIDTH'(-z_diff) : COORD_WIDTH'(z_diff);
      // the centre halving moves to the divisor: twice the sensing gap
      divisor = {z_gap, 1'b0};
      z_equal = (z_diff == '0);
   end

   // ---------------------------------------------------------------- entry
   always_comb begin
      num_in = NUMW'(req_offset) + NUMW'(req_offset)
             + NUMW'(cfg_ff[REG_FIRST_LOW_EDGE]) + NUMW'(cfg_ff[REG_FIRST_HIGH_EDGE])
             - NUMW'(cfg_ff[REG_SECOND_LOW_EDGE]) - NUMW'(cfg_ff[REG_SECOND_HIGH_EDGE]);
      entry_tag_in.vld = start && !busy_ff;
      entry_tag_in.deg = z_equal;
      num_mag = num_ff[NUMW-1] ? NW'(-num_ff) : NW'(num_ff);
      num_neg = num_ff[NUMW-1] ^ z_diff[COORD_WIDTH];
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------- divider
   always_comb begin
      for (int k = 0; k < DW; k++) begin
         div_trial[k]  = {div_rem_ff[k], div_x_ff[k][DW-1]};
         div_ge[k]     = (div_trial[k] >= {1'b0, divisor});
         div_rem_in[k] = div_ge[k] ? DDW'(div_trial[k] - {1'b0, divisor})
                                   : div_trial[k][DDW-1:0];
         div_x_in[k]   = {div_x_ff[k][DW-2:0], div_ge[k]};
      end
   end

   // ---------------------------------------------------------------- slope
   always_comb begin
      // quotient carries one extra fraction bit: add one and drop it to round
      q_inc = {1'b0, div_x_ff[DW]} + (DW + 1)'(1);
      q_ovf = ((div_x_ff[DW] >> SLOPE_OVF_BIT) != DW'(0));
      m_in  = q_ovf ? SLOPE_SAT : q_inc[SMW:1];
      m_pad = PADW'(m_ff);
   end

   // ---------------------------------------------------------------- faces
   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         mul_neg_in[f] = m_neg_ff ^ face_z[f][COORD_WIDTH-1];
         for (int j = 0; j < NCH; j++) begin
            mul_pp_in[f][j] = PPW'(m_pad[j*MUL_CHUNK +: MUL_CHUNK]) * PPW'(z_mag[f]);
         end
      end
   end

   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         sum_prod_in[f] = '0;
         for (int j = 0; j < NCH; j++) begin
            sum_prod_in[f] = sum_prod_in[f] + (PW'(mul_pp_ff[f][j]) << (j * MUL_CHUNK));
         end
      end
   end

   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         rnd_full[f]   = {1'b0, sum_prod_ff[f]} + ROUND_HALF;
         rnd_shift[f]  = rnd_full[f][PW:SLOPE_FRAC_BITS];
         rnd_sat[f]    = (CMPW'(rnd_shift[f]) > SHIFT_SAT_VAL);
         rnd_mag_in[f] = rnd_sat[f] ? SMAGW'(SHIFT_SAT_VAL) : SMAGW'(rnd_shift[f]);
      end
   end

   // move each edge against the face shift: edge - shift
   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         if (rnd_neg_ff[f]) begin
            edge_min_in[f] = EW'(face_lo[f]) + EW'(rnd_mag_ff[f]);
            edge_max_in[f] = EW'(face_hi[f]) + EW'(rnd_mag_ff[f]);
         end else begin
            edge_min_in[f] = EW'(face_lo[f]) - EW'(rnd_mag_ff[f]);
            edge_max_in[f] = EW'(face_hi[f]) - EW'(rnd_mag_ff[f]);
         end
      end
   end

   // ---------------------------------------------------------------- intersect
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         pair_lo_in[p] = (edge_min_ff[2*p] > edge_min_ff[2*p+1]) ? edge_min_ff[2*p]
                                                                 : edge_min_ff[2*p+1];
         pair_hi_in[p] = (edge_max_ff[2*p] < edge_max_ff[2*p+1]) ? edge_max_ff[2*p]
                                                                 : edge_max_ff[2*p+1];
      end
      span_lo_in = (pair_lo_ff[0] > pair_lo_ff[1]) ? pair_lo_ff[0] : pair_lo_ff[1];
      span_hi_in = (pair_hi_ff[0] < pair_hi_ff[1]) ? pair_hi_ff[0] : pair_hi_ff[1];
   end

   always_comb begin
      span_diff = DIFW'(span_hi_ff) - DIFW'(span_lo_ff);
      if (span_tag_ff.deg || (span_lo_ff >= span_hi_ff)) begin
         out_len_in = '0;
      end else if (span_diff[DIFW-1:COORD_WIDTH] != '0) begin
         out_len_in = '1;
      end else begin
         out_len_in = span_diff[COORD_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         entry_tag_ff <= '0;
         for (int k = 0; k <= DW; k++) begin
            div_tag_ff[k] <= '0;
         end
         m_tag_ff    <= '0;
         mul_tag_ff  <= '0;
         sum_tag_ff  <= '0;
         rnd_tag_ff  <= '0;
         edge_tag_ff <= '0;
         pair_tag_ff <= '0;
         span_tag_ff <= '0;
         out_tag_ff  <= '0;
      end else begin
         busy_ff       <= 1'b0;
         entry_tag_ff  <= entry_tag_in;
         div_tag_ff[0] <= entry_tag_ff;
         for (int k = 0; k < DW; k++) begin
            div_tag_ff[k+1] <= div_tag_ff[k];
         end
         m_tag_ff    <= div_tag_ff[DW];
         mul_tag_ff  <= m_tag_ff;
         sum_tag_ff  <= mul_tag_ff;
         rnd_tag_ff  <= sum_tag_ff;
         edge_tag_ff <= rnd_tag_ff;
         pair_tag_ff <= edge_tag_ff;
         span_tag_ff <= pair_tag_ff;
         out_tag_ff  <= span_tag_ff;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      div_rem_ff[0] <= '0;
      div_x_ff[0]   <= {num_mag, (SLOPE_FRAC_BITS + 1)'(0)};
      div_neg_ff[0] <= num_neg;
      for (int k = 0; k < DW; k++) begin
         div_rem_ff[k+1] <= div_rem_in[k];
         div_x_ff[k+1]   <= div_x_in[k];
         div_neg_ff[k+1] <= div_neg_ff[k];
      end
      m_ff     <= m_in;
      m_neg_ff <= div_neg_ff[DW];
      for (int f = 0; f < FACE_COUNT; f++) begin
         for (int j = 0; j < NCH; j++) begin
            mul_pp_ff[f][j] <= mul_pp_in[f][j];
         end
         mul_neg_ff[f]  <= mul_neg_in[f];
         sum_prod_ff[f] <= sum_prod_in[f];
         sum_neg_ff[f]  <= mul_neg_ff[f];
         rnd_mag_ff[f]  <= rnd_mag_in[f];
         rnd_neg_ff[f]  <= sum_neg_ff[f];
         edge_min_ff[f] <= edge_min_in[f];
         edge_max_ff[f] <= edge_max_in[f];
      end
      for (int p = 0; p < 2; p++) begin
         pair_lo_ff[p] <= pair_lo_in[p];
         pair_hi_ff[p] <= pair_hi_in[p];
      end
      span_lo_ff <= span_lo_in;
      span_hi_ff <= span_hi_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_strobe         = out_tag_ff.vld;
   assign rsp_overlap_length = out_len_ff;
   assign rsp_degenerate     = out_tag_ff.deg;

endmodule

// ===== src/tpao_checker.sv =====
module tpao_checker #(
   parameter int COORD_WIDTH     = 24,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic [COORD_WIDTH-1:0] rsp_overlap_length,
   input logic                   rsp_degenerate
);

   // edges from the taking edge to the sample that sees the strobe
   localparam int LATENCY = COORD_WIDTH + SLOPE_FRAC_BITS + 13;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && busy)
      else $error("strobe or ready seen straight after reset");

   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("item taken but no result at the expected cycle");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |-> (rsp_overlap_length == '0))
      else $error("degenerate result with nonzero length");

endmodule

bind two_plane_aperture_overlap tpao_checker #(
   .COORD_WIDTH     (COORD_WIDTH),
   .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
) u_tpao_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import tpao_pkg::*;

   localparam int     CW      = 24;
   localparam int     FRAC    = 16;
   localparam int     CMIN    = -8388608;
   localparam int     CMAX    = 8388607;
   localparam longint LEN_MAX = (64'sd1 <<< CW) - 1;
   localparam logic [63:0]  SLOPE_CAP = (64'd1 << 63) - 64'd1;
   localparam logic [127:0] SHIFT_CAP = 128'd1 << 61;
   localparam int     RANDOM_ITEMS = 1650;

   typedef struct packed {
      logic [CW-1:0] offset;
      logic [CW-1:0] length;
      logic          degenerate;
   } overlap_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_offset = '0;
   logic                 csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = REG_FIRST_LOW_EDGE;
   logic [CW-1:0]        csr_wdata = '0;
   logic                 rsp_strobe;
   logic [CW-1:0]        rsp_overlap_length;
   logic                 rsp_degenerate;

   logic [CW-1:0] offset_backlog [$];
   overlap_type   overlap_due [$];
   logic [CW-1:0] unit_reg [CSR_COUNT];
   logic [CW-1:0] geom_plan [CSR_COUNT];
   logic          took = 1'b0;
   int            idle_left = 0;
   bit            steady_run = 1'b0;
   int            mismatch_count = 0;

   two_plane_aperture_overlap dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_offset         (req_offset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_overlap_length (rsp_overlap_length),
      .rsp_degenerate     (rsp_degenerate)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint sx(input logic [CW-1:0] v);
      return $signed({{(64-CW){v[CW-1]}}, v});
   endfunction

   function automatic int jitter(input int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   // overlap of the four projected intervals for one offset, from the shadow registers
   function automatic overlap_type predict_overlap(input logic [CW-1:0] off_bits);
      longint       lo_e [2];
      longint       hi_e [2];
      longint       sense_z [2];
      longint       other_z [2];
      longint       num, den, z, shift, rmin, rmax, span;
      logic [63:0]  n, d, slope, zmag;
      logic [127:0] prod;
      logic         slope_neg, shift_neg;
      int           u, k;
      overlap_type  res;
      res.offset     = off_bits;
      res.length     = '0;
      res.degenerate = 1'b0;
      lo_e[0]    = sx(unit_reg[REG_FIRST_LOW_EDGE]);
      hi_e[0]    = sx(unit_reg[REG_FIRST_HIGH_EDGE]);
      sense_z[0] = sx(unit_reg[REG_FIRST_SENSE_Z]);
      other_z[0] = sx(unit_reg[REG_FIRST_OTHER_Z]);
      lo_e[1]    = sx(unit_reg[REG_SECOND_LOW_EDGE]);
      hi_e[1]    = sx(unit_reg[REG_SECOND_HIGH_EDGE]);
      sense_z[1] = sx(unit_reg[REG_SECOND_SENSE_Z]);
      other_z[1] = sx(unit_reg[REG_SECOND_OTHER_Z]);
      den = 2 * (sense_z[0] - sense_z[1]);
      if (den == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      // centres halved exactly: both sides carry the factor of two
      num = 2 * sx(off_bits) + lo_e[0] + hi_e[0] - lo_e[1] - hi_e[1];
      slope_neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      if (((n / d) >> (63 - FRAC)) != 64'd0) begin
         slope = SLOPE_CAP;
      end else begin
         // one extra quotient bit, then round half away from zero
         slope = ((n << (FRAC + 1)) / d + 64'd1) >> 1;
      end
      rmin = 0;
      rmax = 0;
      for (k = 0; k < FACE_COUNT; k++) begin
         u = k / 2;
         z = (k % 2 == 1) ? other_z[u] : sense_z[u];
         shift_neg = slope_neg != (z < 0);
         zmag = (z < 0) ? -z : z;
         prod = ({64'd0, slope} * {64'd0, zmag} + (128'd1 << (FRAC - 1))) >> FRAC;
         if (prod > SHIFT_CAP) prod = SHIFT_CAP;
         shift = longint'(prod[63:0]);
         if (shift_neg) shift = -shift;
         if (k == 0 || lo_e[u] - shift > rmin) rmin = lo_e[u] - shift;
         if (k == 0 || hi_e[u] - shift < rmax) rmax = hi_e[u] - shift;
      end
      if (rmin < rmax) begin
         span = rmax - rmin;
         if (span > LEN_MAX) span = LEN_MAX;
         res.length = CW'(span);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_run || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver: hold an item until taken, then idle for a drawn gap
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else if (start && !took) begin
         // hold
      end else if (idle_left > 0) begin
         start <= 1'b0;
         idle_left = idle_left - 1;
      end else if (offset_backlog.size() != 0) begin
         req_offset <= offset_backlog.pop_front();
         start      <= 1'b1;
         idle_left = pick_gap();
         if ($urandom_range(0, 47) == 0) steady_run = !steady_run;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check results, predict taken items, shadow register writes
   always @(posedge clock) begin
      overlap_type want;
      int          i;
      if (reset) begin
         took <= 1'b0;
         for (i = 0; i < CSR_COUNT; i++) unit_reg[i] <= '0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (overlap_due.size() == 0) begin
               report_mismatch($sformatf("result len=%0d deg=%b with nothing outstanding",
                                         rsp_overlap_length, rsp_degenerate));
            end else begin
               want = overlap_due.pop_front();
               if (rsp_overlap_length !== want.length)
                  report_mismatch($sformatf("offset %0d: length %0d, expected %0d",
                                            $signed(want.offset), rsp_overlap_length,
                                            want.length));
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch($sformatf("offset %0d: degenerate %b, expected %b",
                                            $signed(want.offset), rsp_degenerate,
                                            want.degenerate));
            end
         end
         took <= (start === 1'b1 && busy === 1'b0);
         if (start === 1'b1 && busy === 1'b0) overlap_due.push_back(predict_overlap(req_offset));
         if (csr_we) unit_reg[csr_index] <= csr_wdata;
      end
   end

   // sample at the rising edge, where the driver's last item is already on start
   task automatic wait_idle();
      do @(posedge clock);
      while (offset_backlog.size() != 0 || start || overlap_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_plan();
      int i;
      wait_idle();
      for (i = 0; i < CSR_COUNT; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= csr_reg_type'(i);
         csr_wdata <= geom_plan[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_plan(input int l0, input int h0, input int s0, input int o0,
                           input int l1, input int h1, input int s1, input int o1);
      geom_plan[REG_FIRST_LOW_EDGE]   = CW'(l0);
      geom_plan[REG_FIRST_HIGH_EDGE]  = CW'(h0);
      geom_plan[REG_FIRST_SENSE_Z]    = CW'(s0);
      geom_plan[REG_FIRST_OTHER_Z]    = CW'(o0);
      geom_plan[REG_SECOND_LOW_EDGE]  = CW'(l1);
      geom_plan[REG_SECOND_HIGH_EDGE] = CW'(h1);
      geom_plan[REG_SECOND_SENSE_Z]   = CW'(s1);
      geom_plan[REG_SECOND_OTHER_Z]   = CW'(o1);
   endtask

   // mostly overlapping units with distinct sensing planes; some raw, degenerate or reversed
   task automatic plan_random_geometry();
      int roll, i, w0, w1, b0, b1, z0, sep;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         for (i = 0; i < CSR_COUNT; i++) geom_plan[i] = CW'($urandom());
      end else begin
         w0  = $urandom_range(1, 30000);
         w1  = $urandom_range(1, 30000);
         b0  = jitter(500000);
         b1  = b0 + jitter(w0);
         z0  = jitter(2000000);
         sep = $urandom_range(1, 500000);
         if ($urandom_range(0, 1)) sep = -sep;
         set_plan(b0, b0 + w0, z0, z0 + jitter(5000),
                  b1, b1 + w1, z0 + sep, z0 + sep + jitter(5000));
         if (roll < 27) begin
            geom_plan[REG_SECOND_SENSE_Z] = geom_plan[REG_FIRST_SENSE_Z];
         end else if (roll < 35) begin
            geom_plan[REG_FIRST_LOW_EDGE]  = CW'(b0 + w0);
            geom_plan[REG_FIRST_HIGH_EDGE] = CW'(b0);
         end
      end
   endtask

   // offsets near the aligned position, with raw values and values near zero or the range ends
   function automatic logic [CW-1:0] draw_offset();
      longint aligned, pick, spread;
      int     roll;
      roll = $urandom_range(0, 99);
      if (roll >= 65 && roll < 88) return CW'($urandom());
      aligned = -((sx(geom_plan[REG_FIRST_LOW_EDGE]) + sx(geom_plan[REG_FIRST_HIGH_EDGE])
                 - sx(geom_plan[REG_SECOND_LOW_EDGE]) - sx(geom_plan[REG_SECOND_HIGH_EDGE])) / 2);
      spread = sx(geom_plan[REG_FIRST_HIGH_EDGE]) - sx(geom_plan[REG_FIRST_LOW_EDGE]);
      if (spread < 0) spread = -spread;
      spread = (spread % 100000) + 16;
      if (roll < 65) begin
         pick = aligned + jitter(int'(spread));
      end else begin
         case ($urandom_range(0, 3))
            0:       pick = CMAX - int'($urandom_range(0, 15));
            1:       pick = CMIN + int'($urandom_range(0, 15));
            2:       pick = jitter(8);
            default: pick = -1;
         endcase
      end
      if (pick > CMAX) pick = CMAX;
      if (pick < CMIN) pick = CMIN;
      return CW'(pick);
   endfunction

   initial begin
      int random_sent, batch, i;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers still at reset: sensing planes coincide
      offset_backlog.push_back(CW'(0));
      offset_backlog.push_back(CW'(CMAX));
      offset_backlog.push_back(CW'(CMIN));

      set_plan(-2560, 2560, 0, 1280, -2560, 2560, 25600, 26880);
      apply_plan();
      offset_backlog.push_back(CW'(0));
      offset_backlog.push_back(CW'(1));
      offset_backlog.push_back(CW'(-1));
      offset_backlog.push_back(CW'(1000));
      offset_backlog.push_back(CW'(-1000));
      offset_backlog.push_back(CW'(2000));
      offset_backlog.push_back(CW'(CMAX));
      offset_backlog.push_back(CW'(CMIN));

      // widest intervals, planes at opposite range ends
      set_plan(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX);
      apply_plan();
      offset_backlog.push_back(CW'(0));
      offset_backlog.push_back(CW'(CMAX));

      // steepest slope: planes one step apart, edges at the range ends
      set_plan(CMAX, CMAX, 1, CMAX, CMIN, CMIN, 0, CMIN);
      apply_plan();
      offset_backlog.push_back(CW'(CMAX));
      offset_backlog.push_back(CW'(CMIN));

      // first unit with its edges reversed
      set_plan(5000, -5000, 0, 1280, -2560, 2560, 25600, 26880);
      apply_plan();
      offset_backlog.push_back(CW'(0));
      offset_backlog.push_back(CW'(100));

      // intervals that just touch at zero slope
      set_plan(0, 2560, 0, 0, 2560, 5120, 25600, 25600);
      apply_plan();
      offset_backlog.push_back(CW'(2560));
      offset_backlog.push_back(CW'(2561));

      // equal sensing planes away from zero
      set_plan(-2560, 2560, 777, 1500, -2560, 2560, 777, -900);
      apply_plan();
      offset_backlog.push_back(CW'(0));
      offset_backlog.push_back(CW'(12345));

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         plan_random_geometry();
         apply_plan();
         batch = $urandom_range(15, 70);
         for (i = 0; i < batch; i++) offset_backlog.push_back(draw_offset());
         random_sent += batch;
      end

      wait_idle();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
